// File: rtl/core/tqs_pkg.sv
package tqs_pkg;

  localparam int TimeW = 48;
  localparam int IdW = 32;
  localparam int MaxFire = 16;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_FIRED = 3'd0,
    KIND_IDLE = 3'd1,
    KIND_ADDED = 3'd2,
    KIND_FULL = 3'd3,
    KIND_REMOVED = 3'd4,
    KIND_NOT_FOUND = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FIRE,
    ST_SCAN_ADD,
    ST_SCAN_REMOVE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] tick_amount;
    logic [31:0] delay;
    logic [31:0] period;
    logic [31:0] target_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] timer_id;
    logic last;
  } out_word_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [IdW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW-IdW+1){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

// File: rtl/core/timer_queue_scheduler.sv
// Channel | Direction | Payload      | Handshake
// in      | input     | in_word_t    | in_valid / in_stall
// out     | output    | out_word_t   | out_valid / out_stall
// Each item is handled by one compare unit that walks the slots one per cycle.
// Add, remove and the unused command each scan the slots at most once. A tick
// rescans them for each firing and emits one word per firing, at most MaxFire,
// or a single idle word when nothing fires.
// Reset clears time, the id counter and all slot valid bits at once.
// A stalled output word holds the sequencer; no new item is taken meanwhile.
module timer_queue_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tqs_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output tqs_pkg::out_word_t out_data
);
  import tqs_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(MaxFire + 1);

  state_t state, state_next;
  logic [TimeW-1:0] now_time;
  logic [IdW-1:0] next_free_id;
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] fired;
  logic [TimeW-1:0] slot_deadline [SLOTS];
  logic [IdW-1:0] slot_period [SLOTS];
  logic [IdW-1:0] slot_id [SLOTS];

  in_word_t item;
  logic [CW-1:0] idx;
  logic [SW-1:0] cur;
  logic found;
  logic [SW-1:0] best;
  logic [TimeW-1:0] best_dl;
  logic [IdW-1:0] best_id;
  logic [FW-1:0] nfired;

  function automatic cmd_t item_cmd(input logic [1:0] c);
    return cmd_t'(c);
  endfunction

  // Candidate test for the slot under the scan pointer.
  logic cand_due, cand_better, add_hit, rem_hit;
  assign cur = idx[SW-1:0];
  assign cand_due = slot_valid[cur] && !fired[cur] && slot_deadline[cur] <= now_time;
  assign cand_better = !found || slot_deadline[cur] < best_dl ||
                       (slot_deadline[cur] == best_dl && slot_id[cur] < best_id);
  assign add_hit = !slot_valid[cur];
  assign rem_hit = slot_valid[cur] && slot_id[cur] == item.target_id;
  logic scan_done;
  assign scan_done = idx == CW'(SLOTS - 1);
  logic fire_more;
  assign fire_more = found && (nfired + 1'b1 < FW'(MaxFire));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) begin
        case (item_cmd(in_data.cmd))
          CMD_TICK: state_next = ST_SCAN_FIRE;
          CMD_ADD: state_next = ST_SCAN_ADD;
          CMD_REMOVE: state_next = ST_SCAN_REMOVE;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_SCAN_FIRE: if (scan_done) state_next = (nfired == '0) ? ST_UPDATE : ST_EMIT;
      ST_SCAN_ADD: if (scan_done || add_hit) state_next = ST_UPDATE;
      ST_SCAN_REMOVE: if (scan_done || rem_hit) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (item_cmd(item.cmd) == CMD_TICK && fire_more) state_next = ST_SCAN_FIRE;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (!out_stall) state_next = out_data.last ? ST_IDLE : ST_UPDATE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    out_valid = state == ST_EMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      now_time <= '0;
      next_free_id <= '0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_valid) begin
          item <= in_data;
          idx <= '0;
          found <= 1'b0;
          fired <= '0;
          nfired <= '0;
          out_data.timer_id <= '0;
          out_data.kind <= KIND_IDLE;
          out_data.last <= 1'b1;
          if (in_data.cmd == CMD_TICK)
            now_time <= sat_add(now_time, {{(IdW-16){1'b0}}, in_data.tick_amount});
        end
        ST_SCAN_FIRE: begin
          if (cand_due && cand_better) begin
            found <= 1'b1;
            best <= cur;
            best_dl <= slot_deadline[cur];
            best_id <= slot_id[cur];
          end
          // After a firing, the scan looks ahead before the held word goes out,
          // so that word is marked last only when nothing else is due or MaxFire is reached.
          if (scan_done && nfired != '0)
            out_data.last <= !(found || cand_due);
          idx <= idx + 1'b1;
        end
        ST_SCAN_ADD, ST_SCAN_REMOVE: begin
          if ((state == ST_SCAN_ADD) ? add_hit : rem_hit) begin
            found <= 1'b1;
            best <= cur;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          case (item_cmd(item.cmd))
            CMD_TICK: begin
              idx <= '0;
              found <= 1'b0;
              if (found) begin
                fired[best] <= 1'b1;
                nfired <= nfired + 1'b1;
                out_data.kind <= KIND_FIRED;
                out_data.timer_id <= best_id;
                out_data.last <= !fire_more;
                if (slot_period[best] != '0)
                  slot_deadline[best] <= sat_add(now_time, slot_period[best]);
                else
                  slot_valid[best] <= 1'b0;
              end else begin
                out_data.kind <= KIND_IDLE;
                out_data.last <= 1'b1;
              end
            end
            CMD_ADD: begin
              if (found) begin
                slot_valid[best] <= 1'b1;
                slot_deadline[best] <= sat_add(now_time, item.delay);
                slot_period[best] <= item.period;
                slot_id[best] <= next_free_id;
                next_free_id <= next_free_id + 1'b1;
                out_data.kind <= KIND_ADDED;
                out_data.timer_id <= next_free_id;
              end else begin
                out_data.kind <= KIND_FULL;
              end
            end
            CMD_REMOVE: begin
              if (found) slot_valid[best] <= 1'b0;
              out_data.kind <= found ? KIND_REMOVED : KIND_NOT_FOUND;
              out_data.timer_id <= item.target_id;
            end
            default: out_data.kind <= KIND_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tqs_checker.sv
module tqs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input tqs_pkg::out_word_t out_data
);
  import tqs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a word is pending");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kind <= KIND_NOT_FOUND)
    else $error("bad result kind");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_FIRED |-> out_data.last)
    else $error("non-fire word not last");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a word");

endmodule

bind timer_queue_scheduler tqs_checker u_tqs_checker (.*);

// File: bench/tb_timer_queue_scheduler.sv
`timescale 1ns / 100ps

module tb_timer_queue_scheduler;
  import tqs_pkg::*;

  localparam int NumSlots = 16;
  localparam logic [47:0] TimeTop = 48'hFFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;

  timer_queue_scheduler #(.SLOTS(NumSlots)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Scoreboard copy of the timer table.
  logic [47:0] clock_ms = '0;
  logic [31:0] id_counter = '0;
  logic armed [NumSlots] = '{default: 1'b0};
  logic [47:0] due_at [NumSlots] = '{default: '0};
  logic [31:0] reload_ms [NumSlots] = '{default: '0};
  logic [31:0] owner_id [NumSlots] = '{default: '0};

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int mismatches;
  int words_sent;
  int words_checked;
  int fired_seen;
  bit hold_req;
  bit paused;
  bit in_took;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [47:0] clamp_add(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? TimeTop : s[47:0];
  endfunction

  task automatic push_result(kind_t k, logic [31:0] id, logic fin);
    out_word_t w;
    w.kind = k;
    w.timer_id = id;
    w.last = fin;
    expected_words.push_back(w);
  endtask

  task automatic predict_word(in_word_t w);
    logic done [NumSlots];
    int best;
    int count;
    int slot;
    count = 0;
    for (int i = 0; i < NumSlots; i++) done[i] = 1'b0;
    case (cmd_t'(w.cmd))
      CMD_TICK: begin
        clock_ms = clamp_add(clock_ms, {16'd0, w.tick_amount});
        while (count < MaxFire) begin
          best = -1;
          for (int i = 0; i < NumSlots; i++) begin
            if (armed[i] && !done[i] && due_at[i] <= clock_ms) begin
              if (best < 0 || due_at[i] < due_at[best] ||
                  (due_at[i] == due_at[best] && owner_id[i] < owner_id[best]))
                best = i;
            end
          end
          if (best < 0) break;
          done[best] = 1'b1;
          if (count > 0) expected_words[$].last = 1'b0;
          push_result(KIND_FIRED, owner_id[best], 1'b1);
          count++;
          if (reload_ms[best] != 0) due_at[best] = clamp_add(clock_ms, reload_ms[best]);
          else armed[best] = 1'b0;
        end
        if (count == 0) push_result(KIND_IDLE, 32'd0, 1'b1);
      end
      CMD_ADD: begin
        slot = -1;
        for (int i = 0; i < NumSlots; i++) begin
          if (slot < 0 && !armed[i]) slot = i;
        end
        if (slot < 0) begin
          push_result(KIND_FULL, 32'd0, 1'b1);
        end else begin
          armed[slot] = 1'b1;
          due_at[slot] = clamp_add(clock_ms, w.delay);
          reload_ms[slot] = w.period;
          owner_id[slot] = id_counter;
          push_result(KIND_ADDED, id_counter, 1'b1);
          id_counter = id_counter + 1;
        end
      end
      CMD_REMOVE: begin
        slot = -1;
        for (int i = 0; i < NumSlots; i++) begin
          if (slot < 0 && armed[i] && owner_id[i] == w.target_id) slot = i;
        end
        if (slot >= 0) armed[slot] = 1'b0;
        push_result(slot >= 0 ? KIND_REMOVED : KIND_NOT_FOUND, w.target_id, 1'b1);
      end
      default: push_result(KIND_IDLE, 32'd0, 1'b1);
    endcase
  endtask

  function automatic in_word_t make_word(cmd_t c, logic [15:0] t, logic [31:0] d,
                                         logic [31:0] p, logic [31:0] id);
    in_word_t w;
    w.cmd = c;
    w.tick_amount = t;
    w.delay = d;
    w.period = p;
    w.target_id = id;
    return w;
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Sender: a word is offered at the falling edge and accepted at a rising edge.
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (in_valid && !in_took) begin
      // Hold the word steady until the block takes it.
    end else if (send_gap > 0 || paused || pending_words.size() == 0) begin
      if (send_gap > 0) send_gap--;
      in_valid <= 1'b0;
    end else begin
      in_data <= pending_words.pop_front();
      in_valid <= 1'b1;
      send_gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
    end
  end

  always @(posedge clk) begin
    in_took = !rst && in_valid && !in_stall;
    if (in_took) begin
      predict_word(in_data);
      words_sent++;
    end
  end

  // Receiver stall, with one long hold-off counted here.
  int stall_gap;
  int hold_left;
  bit hold_used;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_gap = 0;
      hold_left = 0;
      hold_used = 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 399;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) stall_gap = gap_length();
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word %p", out_data);
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.kind == KIND_FIRED) fired_seen++;
        if (out_data.kind !== exp_w.kind || out_data.timer_id !== exp_w.timer_id ||
            out_data.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     exp_w.kind, exp_w.timer_id, exp_w.last,
                     out_data.kind, out_data.timer_id, out_data.last);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    paused = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tick, unused command, adds with tied deadlines up to a full table, removes, a long tick.
    pending_words.push_back(make_word(CMD_TICK, 16'd0, 32'd0, 32'd0, 32'd0));
    pending_words.push_back(make_word(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(CMD_REMOVE, 16'd0, 32'd0, 32'd0, 32'd0));
    for (int i = 0; i < NumSlots; i++)
      pending_words.push_back(make_word(CMD_ADD, 16'd0, (i % 2) ? 32'd5 : 32'd3,
                                        (i % 3 == 0) ? 32'd0 : 32'd4, 32'd0));
    pending_words.push_back(make_word(CMD_ADD, 16'd0, 32'd1, 32'd1, 32'd0));
    pending_words.push_back(make_word(CMD_REMOVE, 16'd0, 32'd0, 32'd0, 32'd3));
    pending_words.push_back(make_word(CMD_REMOVE, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(CMD_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0));

    // Long receiver hold-off while words keep coming, so the block backs up.
    @(negedge clk);
    hold_req = 1'b1;
    wait_drained();

    // Sender pause until every expected word is back.
    paused = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);
    paused = 1'b0;

    for (int n = 0; n < 210; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_words.push_back(make_word(CMD_ADD, 16'($urandom()),
                                            pick_span(), ($urandom_range(0, 2) == 0) ?
                                            32'd0 : pick_span(), $urandom()));
        4, 5, 6: pending_words.push_back(make_word(CMD_TICK,
                                         ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                                         16'($urandom_range(0, 2000)),
                                         $urandom(), $urandom(), $urandom()));
        7, 8: pending_words.push_back(make_word(CMD_REMOVE, 16'($urandom()), $urandom(),
                                      $urandom(), ($urandom_range(0, 3) == 0) ?
                                      $urandom() : id_counter - $urandom_range(1, 20)));
        default: pending_words.push_back(make_word(CMD_NONE, 16'($urandom()), $urandom(),
                                         $urandom(), $urandom()));
      endcase
    end
    // Add timers with the largest delay and period, then advance time in large ticks.
    for (int n = 0; n < 6; n++) begin
      pending_words.push_back(make_word(CMD_ADD, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
      for (int k = 0; k < 4; k++)
        pending_words.push_back(make_word(CMD_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0));
    end
    wait_drained();
    repeat (400) @(posedge clk);

    $display("Run sent %0d words and checked %0d output words, %0d of them timer firings.",
             words_sent, words_checked, fired_seen);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Mismatches: %0d, words still expected: %0d", mismatches,
               expected_words.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for output words");
    $display("Verification failed");
    $finish;
  end

endmodule
